### rtl/locality_node_picker_defines.svh
// Assertion macros used by the checker file of the node picker.
`ifndef LOCALITY_NODE_PICKER_DEFINES_SVH
`define LOCALITY_NODE_PICKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LNP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lnp_pkg.sv
`default_nettype none
package lnp_pkg;

	localparam logic [1:0] MODE_LOCALITY = 2'd0;
	localparam logic [1:0] MODE_SPREAD   = 2'd1;
	localparam logic [1:0] MODE_AFFINITY = 2'd2;

	typedef struct packed {
		logic        first;
		logic        last;
		logic [1:0]  mode;
		logic [4:0]  affinity_node;
		logic        contributes;
		logic [4:0]  holder_node;
		logic [47:0] size_bytes;
	} in_item_t;

	typedef struct packed {
		logic [4:0] target_node;
		logic       use_fallback;
		logic       by_locality;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd;
		logic add;
		logic wr;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic contrib;
		logic last;
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_ADD    = 5'b00100,
		ST_WRITE  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

endpackage
`default_nettype wire

### rtl/locality_node_picker.sv
// Node picker for one task at a time.
// An item is taken when start is high and busy is low. Items of a task come
// as a run: the first clears all node totals and the leader, and in locality
// mode each contributing item adds its size to the total of its holder node.
// An item with last set produces one result on result, marked by a one-cycle
// result_valid pulse; the receiver cannot hold it off and takes it there.
// known_nodes is to be written through cfg_we and cfg_wdata only while the block
// is idle; the block itself does not enforce this. A contributing item keeps busy
// high through the memory read, add, and write with leader compare states; any
// other item only through the read state. A last item then passes a result state
// that builds the result, and result_valid is registered from it. busy stays high
// until the item is done, so the block takes one item at a time.
// Reset clears known_nodes, the leader and all per-node valid bits, so every
// total reads as zero; no clearing pass is needed.
`default_nettype none
module locality_node_picker #(
	parameter int NODE_SLOTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lnp_pkg::in_item_t item,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	output lnp_pkg::result_t       result,
	output logic                   result_valid
);

	lnp_pkg::cmd_t    cmd;
	lnp_pkg::status_t status;

	lnp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lnp_dp #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

### rtl/lnp_ctrl.sv
`default_nettype none
module lnp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire lnp_pkg::status_t status,
	output lnp_pkg::cmd_t         cmd,
	output logic                  busy
);

	lnp_pkg::state_t state_q;
	lnp_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			lnp_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = lnp_pkg::ST_READ;
				end
			end
			lnp_pkg::ST_READ: begin
				cmd.rd = 1'b1;
				if (status.contrib) begin
					state_nxt = lnp_pkg::ST_ADD;
				end else if (status.last) begin
					state_nxt = lnp_pkg::ST_RESULT;
				end else begin
					state_nxt = lnp_pkg::ST_IDLE;
				end
			end
			lnp_pkg::ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = lnp_pkg::ST_WRITE;
			end
			lnp_pkg::ST_WRITE: begin
				cmd.wr    = 1'b1;
				state_nxt = status.last ? lnp_pkg::ST_RESULT : lnp_pkg::ST_IDLE;
			end
			lnp_pkg::ST_RESULT: begin
				cmd.emit  = 1'b1;
				state_nxt = lnp_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lnp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lnp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != lnp_pkg::ST_IDLE);

endmodule
`default_nettype wire

### rtl/lnp_dp.sv
`default_nettype none
module lnp_dp #(
	parameter int NODE_SLOTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lnp_pkg::cmd_t     cmd,
	input  wire lnp_pkg::in_item_t item,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	output lnp_pkg::status_t       status,
	output lnp_pkg::result_t       result,
	output logic                   result_valid
);

	localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

	lnp_pkg::in_item_t item_q;
	logic [31:0]       known_q;

	logic [63:0]           mem_q [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] valid_q;
	logic [63:0]           rd_q;
	logic                  rdv_q;
	logic [63:0]           sum_q;

	logic [63:0] best_total_q;
	logic [4:0]  best_slot_q;
	logic        best_valid_q;

	lnp_pkg::result_t result_q;
	logic             strobe_q;

	logic [6:0]       holder_ext;
	logic [6:0]       aff_ext;
	logic             holder_ok;
	logic [IDX_W-1:0] idx;
	logic [63:0]      base;
	logic [64:0]      sum_full;
	logic [63:0]      sum_sat;
	lnp_pkg::result_t result_nxt;

	assign holder_ext = {2'b00, item_q.holder_node};
	assign aff_ext    = {2'b00, item_q.affinity_node};
	assign holder_ok  = (holder_ext < 7'(NODE_SLOTS));
	assign idx        = holder_ext[IDX_W-1:0];

	assign status.contrib = (item_q.mode == lnp_pkg::MODE_LOCALITY) && item_q.contributes
		&& holder_ok;
	assign status.last    = item_q.last;

	// A slot whose valid bit is clear holds a zero total for this task.
	assign base     = rdv_q ? rd_q : 64'd0;
	assign sum_full = {1'b0, base} + {17'd0, item_q.size_bytes};
	assign sum_sat  = sum_full[64] ? {64{1'b1}} : sum_full[63:0];

	always_comb begin
		result_nxt = '0;
		result_nxt.use_fallback = 1'b1;
		case (item_q.mode)
			lnp_pkg::MODE_AFFINITY: begin
				if ((aff_ext < 7'(NODE_SLOTS)) && known_q[item_q.affinity_node]) begin
					result_nxt.target_node  = item_q.affinity_node;
					result_nxt.use_fallback = 1'b0;
				end
			end
			lnp_pkg::MODE_LOCALITY: begin
				if (best_valid_q && known_q[best_slot_q]) begin
					result_nxt.target_node  = best_slot_q;
					result_nxt.use_fallback = 1'b0;
					result_nxt.by_locality  = 1'b1;
				end
			end
			default: begin
				result_nxt.use_fallback = 1'b1;
			end
		endcase
	end

	// Payload and total storage, no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[idx];
		end
		if (cmd.add) begin
			sum_q <= sum_sat;
		end
		if (cmd.wr) begin
			mem_q[idx] <= sum_q;
		end
		if (cmd.emit) begin
			result_q <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q      <= '0;
			valid_q      <= '0;
			rdv_q        <= 1'b0;
			best_total_q <= '0;
			best_slot_q  <= '0;
			best_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cfg_we) begin
				known_q <= cfg_wdata;
			end
			if (cmd.load && item.first) begin
				valid_q      <= '0;
				best_total_q <= '0;
				best_slot_q  <= '0;
				best_valid_q <= 1'b0;
			end
			if (cmd.rd) begin
				rdv_q <= valid_q[idx];
			end
			if (cmd.wr) begin
				valid_q[idx] <= 1'b1;
				// Only a strictly larger total takes the lead, so ties keep the earlier node.
				if (sum_q > best_total_q) begin
					best_total_q <= sum_q;
					best_slot_q  <= item_q.holder_node;
					best_valid_q <= 1'b1;
				end
			end
		end
	end

	assign result       = result_q;
	assign result_valid = strobe_q;

endmodule
`default_nettype wire

### rtl/lnp_checker.sv
`default_nettype none
`include "locality_node_picker_defines.svh"
module lnp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire lnp_pkg::result_t result,
	input wire logic             result_valid
);

	`LNP_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised after accept")
	`LNP_ASSERT_NEXT(a_strobe_pulse, clk, arst_n, result_valid, !result_valid, "result strobe too long")
	`LNP_ASSERT_NOW(a_strobe_idle, clk, arst_n, result_valid, !busy, "result while busy")
	`LNP_ASSERT_NOW(a_fallback_clean, clk, arst_n, result_valid && result.use_fallback, (result.target_node == 5'd0) && !result.by_locality, "fallback with target set")

endmodule

bind locality_node_picker lnp_checker u_lnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result       (result),
	.result_valid (result_valid)
);
`default_nettype wire

### test/tb_locality_node_picker.sv
module tb_locality_node_picker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 32;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [47:0] SIZE_MAX = '1;
	// Longest stretch from an accept to its result, plus margin.
	localparam int SETTLE_CYCLES = 8;

	// Keeps its own copy of the per-node byte totals and the leader, and
	// holds the choice that each accepted last item must produce.
	class node_choice_tracker;
		logic [31:0]      known;
		logic [63:0]      byte_total[SLOTS];
		logic [63:0]      lead_total;
		logic [4:0]       lead_slot;
		bit               lead_valid;
		lnp_pkg::result_t due_q[$];
		int               fails;

		function new();
			known = '0;
			fails = 0;
			clear_totals();
		endfunction

		function void clear_totals();
			foreach (byte_total[i])
				byte_total[i] = '0;
			lead_total = '0;
			lead_slot = '0;
			lead_valid = 1'b0;
		endfunction

		function void set_known(logic [31:0] v);
			known = v;
		endfunction

		function bit slot_ok(logic [4:0] s);
			return (s < SLOTS) && known[s];
		endfunction

		function void take_item(lnp_pkg::in_item_t it);
			logic [64:0]      sum;
			lnp_pkg::result_t r;
			if (it.first)
				clear_totals();
			if (it.mode == lnp_pkg::MODE_LOCALITY && it.contributes
					&& it.holder_node < SLOTS) begin
				sum = {1'b0, byte_total[it.holder_node]} + {17'd0, it.size_bytes};
				if (sum[64])
					sum[63:0] = '1;
				byte_total[it.holder_node] = sum[63:0];
				// Only a strictly larger total takes the lead.
				if (sum[63:0] > lead_total) begin
					lead_total = sum[63:0];
					lead_slot = it.holder_node;
					lead_valid = 1'b1;
				end
			end
			if (it.last) begin
				r = '0;
				r.use_fallback = 1'b1;
				if (it.mode == lnp_pkg::MODE_AFFINITY) begin
					if (slot_ok(it.affinity_node)) begin
						r.target_node = it.affinity_node;
						r.use_fallback = 1'b0;
					end
				end else if (it.mode == lnp_pkg::MODE_LOCALITY) begin
					if (lead_valid && slot_ok(lead_slot)) begin
						r.target_node = lead_slot;
						r.use_fallback = 1'b0;
						r.by_locality = 1'b1;
					end
				end
				due_q.push_back(r);
			end
		endfunction

		function void check_result(lnp_pkg::result_t got);
			lnp_pkg::result_t want;
			if (due_q.size() == 0) begin
				$error("result with no item waiting: target_node %0d use_fallback %0d",
					got.target_node, got.use_fallback);
				fails++;
				return;
			end
			want = due_q.pop_front();
			if (got.target_node !== want.target_node) begin
				$error("target_node: expected %0d, got %0d", want.target_node, got.target_node);
				fails++;
			end
			if (got.use_fallback !== want.use_fallback) begin
				$error("use_fallback: expected %0d, got %0d",
					want.use_fallback, got.use_fallback);
				fails++;
			end
			if (got.by_locality !== want.by_locality) begin
				$error("by_locality: expected %0d, got %0d", want.by_locality, got.by_locality);
				fails++;
			end
		endfunction

		function int outstanding();
			return due_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	lnp_pkg::in_item_t req_item;
	logic              cfg_we;
	logic [31:0]       cfg_wdata;
	lnp_pkg::result_t  pick_result;
	logic              result_valid;

	node_choice_tracker tracker;

	locality_node_picker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (req_item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (pick_result),
		.result_valid (result_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.set_known(cfg_wdata);
			if (start && !busy)
				tracker.take_item(req_item);
			if (result_valid)
				tracker.check_result(pick_result);
		end
	end

	function automatic lnp_pkg::in_item_t mk(logic f, logic l, logic [1:0] m,
			logic [4:0] aff, logic c, logic [4:0] h, logic [47:0] sz);
		lnp_pkg::in_item_t it;
		it.first = f;
		it.last = l;
		it.mode = m;
		it.affinity_node = aff;
		it.contributes = c;
		it.holder_node = h;
		it.size_bytes = sz;
		return it;
	endfunction

	function automatic logic [47:0] pick_size();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(9))
			0: return '0;
			1: return SIZE_MAX;
			2, 3: return 48'($urandom_range(1, 4));
			4: return {32'd0, r[15:0]};
			default: return r[47:0];
		endcase
	endfunction

	task automatic send_item(lnp_pkg::in_item_t it, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending and waits until every pending choice has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0 || busy);
	endtask

	task automatic write_known(logic [31:0] v);
		drain();
		// Extra idle time before the write; drain has already waited for busy to drop.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One task: mostly well formed, with some stray marks and modes mixed in.
	task automatic random_task(int idle_pct, output int n_sent);
		lnp_pkg::in_item_t it;
		int                n;
		int                r;
		bit                skip_first;
		logic [1:0]        task_mode;
		logic [4:0]        base;
		n = $urandom_range(1, 8);
		r = $urandom_range(9);
		task_mode = (r < 6) ? lnp_pkg::MODE_LOCALITY : (r == 6) ? lnp_pkg::MODE_SPREAD :
			(r < 9) ? lnp_pkg::MODE_AFFINITY : MODE_UNUSED;
		skip_first = ($urandom_range(9) == 0);
		base = 5'($urandom_range(31));
		for (int i = 0; i < n; i++) begin
			it.first = ((i == 0) && !skip_first) || ($urandom_range(29) == 0);
			it.last = (i == n - 1) || ($urandom_range(24) == 0);
			it.mode = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : task_mode;
			it.affinity_node = 5'($urandom_range(31));
			it.contributes = ($urandom_range(9) < 8);
			it.holder_node = ($urandom_range(9) < 7) ? base + 5'($urandom_range(3)) :
				5'($urandom_range(31));
			it.size_bytes = pick_size();
			send_item(it, idle_pct);
		end
		n_sent = n;
	endtask

	task automatic random_phase(int n_items, int idle_pct);
		int count;
		int n;
		count = 0;
		while (count < n_items) begin
			random_task(idle_pct, n);
			count += n;
			if ($urandom_range(29) == 0)
				drain();
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_known('1);
		send_item(mk(1, 1, lnp_pkg::MODE_LOCALITY, 0, 0, 0, 0), 0);
		// Equal totals: the earlier node keeps the lead.
		send_item(mk(1, 0, lnp_pkg::MODE_LOCALITY, 0, 1, 31, SIZE_MAX), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 0, SIZE_MAX), 0);
		send_item(mk(1, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 5, 0), 0);
		send_item(mk(1, 0, lnp_pkg::MODE_SPREAD, 0, 1, 3, 100), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_SPREAD, 0, 1, 3, 100), 0);
		send_item(mk(1, 1, lnp_pkg::MODE_AFFINITY, 0, 0, 0, 0), 0);
		send_item(mk(1, 1, lnp_pkg::MODE_AFFINITY, 31, 1, 7, 1), 0);
		send_item(mk(1, 1, MODE_UNUSED, 4, 1, 4, 50), 0);
		// Tasks without a first mark build on the totals left behind.
		send_item(mk(1, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 2, 10), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 4, 5), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 4, 6), 0);
		send_item(mk(1, 0, lnp_pkg::MODE_LOCALITY, 0, 1, 6, 3), 0);
		send_item(mk(0, 0, lnp_pkg::MODE_AFFINITY, 0, 1, 8, 100), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_LOCALITY, 0, 0, 0, 0), 0);
		write_known('0);
		send_item(mk(1, 1, lnp_pkg::MODE_AFFINITY, 7, 0, 0, 0), 0);
		send_item(mk(1, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 1, 9), 0);
		write_known(32'h0000_0002);
		send_item(mk(1, 0, lnp_pkg::MODE_LOCALITY, 0, 1, 1, 9), 0);
		send_item(mk(0, 1, lnp_pkg::MODE_LOCALITY, 0, 1, 3, 4), 0);

		write_known('1);
		random_phase(100, 0);
		write_known($urandom());
		random_phase(100, 46);
		write_known('0);
		random_phase(40, 0);
		write_known(32'hAAAA_5555);
		random_phase(100, 37);
		write_known($urandom());
		random_phase(100, 46);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		#1;
		if (tracker.fails == 0 && tracker.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
